>>> hw/rtl/lcdnw_pkg.sv
// lcdnw_pkg: types, constants and lookup functions for the character-lcd nibble writer
// no dependencies; used by the interfaces, the divide unit and the top level
`timescale 1ns / 1ps
`default_nettype none

package lcdnw_pkg;

   localparam int VALUE_W            = 32;
   localparam int WAIT_W             = 16;
   localparam int BYTE_W             = 8;
   localparam int NIBBLE_W           = 4;
   localparam int REM_W              = 4;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 16;
   localparam int STEP_W             = 3;
   localparam int MAX_DIGITS_DEFAULT = 10;
   localparam int DECIMAL_BASE       = 10;

   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 3'd6;

   localparam logic [BYTE_W-1:0] CMD_WAKE     = 8'h03;
   localparam logic [BYTE_W-1:0] CMD_FOUR_BIT = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
   localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'd48;

   localparam logic [WAIT_W-1:0] LONG_PAUSE  = 16'd13330;
   localparam logic [WAIT_W-1:0] SHORT_PAUSE = 16'd450;

   localparam logic [BYTE_W-1:0] FUNCTION_SET_RESET    = 8'd40;
   localparam logic [BYTE_W-1:0] DISPLAY_CONTROL_RESET = 8'd14;
   localparam logic [WAIT_W-1:0] COMMAND_WAIT_RESET    = 16'd2666;
   localparam logic [WAIT_W-1:0] DATA_WAIT_RESET       = 16'd3;

   typedef enum logic [1:0] {
      MODE_COMMAND = 2'd0,
      MODE_DATA    = 2'd1,
      MODE_NUMBER  = 2'd2,
      MODE_INIT    = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FUNCTION_SET    = 2'd0,
      CSR_DISPLAY_CONTROL = 2'd1,
      CSR_COMMAND_WAIT    = 2'd2,
      CSR_DATA_WAIT       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SEND
   } state_type;

   // steps of the divide-by-ten sequencer, one shared adder pass each
   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_HALVES,
      DIV_FOLD_4,
      DIV_FOLD_8,
      DIV_FOLD_16,
      DIV_TIMES_TEN,
      DIV_DIFFERENCE,
      DIV_ROUND
   } div_step_type;

   typedef struct packed {
      logic done;
      logic busy;
   } div_status_type;

   function automatic logic [BYTE_W-1:0] init_command(input logic [STEP_W-1:0] step,
                                                      input logic [BYTE_W-1:0] fs_cmd,
                                                      input logic [BYTE_W-1:0] dc_cmd);
      logic [BYTE_W-1:0] cmd;
      unique case (step)
         3'd0, 3'd1, 3'd2: cmd = CMD_WAKE;
         3'd3:             cmd = CMD_FOUR_BIT;
         3'd4:             cmd = fs_cmd;
         3'd5:             cmd = CMD_CLEAR;
         default:          cmd = dc_cmd;
      endcase
      return cmd;
   endfunction

   function automatic logic [WAIT_W-1:0] init_pause(input logic [STEP_W-1:0] step);
      logic [WAIT_W-1:0] pause;
      unique case (step)
         3'd0:                   pause = LONG_PAUSE;
         3'd1, 3'd2, 3'd3, 3'd4: pause = SHORT_PAUSE;
         default:                pause = '0;
      endcase
      return pause;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcdnw_if.sv
// lcdnw_req_if and lcdnw_rsp_if: valid/ready channels of the nibble writer
// depends on lcdnw_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lcdnw_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       mode;
   logic [lcdnw_pkg::VALUE_W-1:0]    value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface lcdnw_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             reg_select;
   logic [lcdnw_pkg::NIBBLE_W-1:0]   nibble;
   logic [lcdnw_pkg::WAIT_W-1:0]     strobe_wait;
   logic [lcdnw_pkg::WAIT_W-1:0]     pause_after;
   logic                             last;

   modport source (output valid, output reg_select, output nibble, output strobe_wait,
                   output pause_after, output last, input ready);
   modport sink   (input valid, input reg_select, input nibble, input strobe_wait,
                   input pause_after, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lcdnw_div10.sv
// lcdnw_div10: divide-by-ten unit, shift-and-add reciprocal on one shared adder over seven steps
// depends on lcdnw_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_div10 (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [lcdnw_pkg::VALUE_W-1:0]      dividend,
   output      logic [lcdnw_pkg::VALUE_W-1:0]      quotient,
   output      logic [lcdnw_pkg::REM_W-1:0]        remainder,
   output      lcdnw_pkg::div_status_type          status
);

   localparam int W = lcdnw_pkg::VALUE_W;

   lcdnw_pkg::div_step_type            step_ff;
   lcdnw_pkg::div_step_type            step_in;
   logic                               done_ff;
   logic                               done_in;
   logic [W-1:0]                       num_ff;
   logic [W-1:0]                       acc_ff;
   logic [W-1:0]                       acc_in;
   logic [W-1:0]                       quo_ff;
   logic [W-1:0]                       quo_in;
   logic [lcdnw_pkg::REM_W-1:0]        rem_ff;
   logic [lcdnw_pkg::REM_W-1:0]        rem_in;
   logic [W-1:0]                       add_a;
   logic [W-1:0]                       add_b;
   logic                               add_cin;
   logic [W-1:0]                       add_sum;
   logic [lcdnw_pkg::REM_W:0]          rem_wide;
   logic                               round_up;

   // the one shared adder
   assign add_sum  = add_a + add_b + {{(W-1){1'b0}}, add_cin};
   assign rem_wide = acc_ff[lcdnw_pkg::REM_W:0];
   assign round_up = rem_wide >= (lcdnw_pkg::REM_W+1)'(lcdnw_pkg::DECIMAL_BASE);

   // next step
   always_comb begin
      step_in = step_ff;
      unique case (step_ff)
         lcdnw_pkg::DIV_IDLE:       step_in = lcdnw_pkg::DIV_IDLE;
         lcdnw_pkg::DIV_HALVES:     step_in = lcdnw_pkg::DIV_FOLD_4;
         lcdnw_pkg::DIV_FOLD_4:     step_in = lcdnw_pkg::DIV_FOLD_8;
         lcdnw_pkg::DIV_FOLD_8:     step_in = lcdnw_pkg::DIV_FOLD_16;
         lcdnw_pkg::DIV_FOLD_16:    step_in = lcdnw_pkg::DIV_TIMES_TEN;
         lcdnw_pkg::DIV_TIMES_TEN:  step_in = lcdnw_pkg::DIV_DIFFERENCE;
         lcdnw_pkg::DIV_DIFFERENCE: step_in = lcdnw_pkg::DIV_ROUND;
         lcdnw_pkg::DIV_ROUND:      step_in = lcdnw_pkg::DIV_IDLE;
         default:                   step_in = lcdnw_pkg::DIV_IDLE;
      endcase
      if (start) begin
         step_in = lcdnw_pkg::DIV_HALVES;
      end
   end

   // adder operands and step results
   always_comb begin
      add_a   = acc_ff;
      add_b   = '0;
      add_cin = 1'b0;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      unique case (step_ff)
         lcdnw_pkg::DIV_IDLE: ;
         lcdnw_pkg::DIV_HALVES: begin
            add_a  = num_ff >> 1;
            add_b  = num_ff >> 2;
            acc_in = add_sum;
         end
         lcdnw_pkg::DIV_FOLD_4: begin
            add_b  = acc_ff >> 4;
            acc_in = add_sum;
         end
         lcdnw_pkg::DIV_FOLD_8: begin
            add_b  = acc_ff >> 8;
            acc_in = add_sum;
         end
         lcdnw_pkg::DIV_FOLD_16: begin
            add_b  = acc_ff >> 16;
            acc_in = add_sum;
         end
         lcdnw_pkg::DIV_TIMES_TEN: begin
            // estimate q = acc / 8, then 8q + 2q
            add_a  = {acc_ff[W-1:3], 3'b000};
            add_b  = {2'b00, acc_ff[W-1:3], 1'b0};
            acc_in = add_sum;
            quo_in = {3'b000, acc_ff[W-1:3]};
         end
         lcdnw_pkg::DIV_DIFFERENCE: begin
            add_a   = num_ff;
            add_b   = ~acc_ff;
            add_cin = 1'b1;
            acc_in  = add_sum;
         end
         lcdnw_pkg::DIV_ROUND: begin
            // estimate is at most one low
            add_a   = quo_ff;
            add_cin = round_up;
            quo_in  = add_sum;
            rem_in  = round_up
                      ? lcdnw_pkg::REM_W'(rem_wide
                                          - (lcdnw_pkg::REM_W+1)'(lcdnw_pkg::DECIMAL_BASE))
                      : rem_wide[lcdnw_pkg::REM_W-1:0];
            done_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lcdnw_pkg::DIV_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
      end
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.done = done_ff;
   assign status.busy = step_ff != lcdnw_pkg::DIV_IDLE;

endmodule

`default_nettype wire

>>> hw/rtl/char_lcd_nibble_writer.sv
// char_lcd_nibble_writer: turns command, data, number and init requests into lcd nibble strobes
// depends on lcdnw_pkg, lcdnw_req_if, lcdnw_rsp_if and lcdnw_div10
//
// Usage: one request item on req_ch (mode, value) yields a burst of strobe items on rsp_ch,
// high nibble first, with last set on the final strobe of the request. A command or data byte
// gives 2 strobes, init gives 14, a number gives 2 per decimal digit (at most MAX_DIGITS).
// req_ch.ready is high only while the block is idle; one request is handled at a time.
// Latency: for command, data and init the first strobe is offered the cycle after the accept.
// A number runs through a shared divide-by-ten unit (one adder over seven steps) once per
// digit, and the first strobe is offered after the last digit is divided; a zero is sent
// without division, offered the cycle after the accept. Strobes then leave one per cycle
// while rsp_ch.ready is high, and the block returns to idle after the last strobe is taken.
// A stalled receiver simply holds the current strobe; nothing is dropped or repeated.
// Synchronous reset returns the sequencer to idle and the csr registers to their defaults.
// Csr writes (csr_we, csr_index, csr_wdata) take effect at once and belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer #(
   parameter int MAX_DIGITS = lcdnw_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   lcdnw_req_if.sink                                 req_ch,
   lcdnw_rsp_if.source                               rsp_ch,
   input  wire logic                                 csr_we,
   input  wire logic [lcdnw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lcdnw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   lcdnw_pkg::state_type                  state_ff;
   lcdnw_pkg::state_type                  state_in;
   lcdnw_pkg::mode_type                   mode_ff;
   lcdnw_pkg::mode_type                   req_mode;
   logic [lcdnw_pkg::BYTE_W-1:0]          byte_ff;
   logic                                  high_ff;
   logic [lcdnw_pkg::STEP_W-1:0]          step_ff;
   logic [CNT_W-1:0]                      count_ff;
   logic [CNT_W-1:0]                      count_inc;
   logic [CNT_W-1:0]                      count_dec;
   logic [lcdnw_pkg::REM_W-1:0]           digit_store [MAX_DIGITS];

   logic [lcdnw_pkg::BYTE_W-1:0]          fs_cmd_ff;
   logic [lcdnw_pkg::BYTE_W-1:0]          dc_cmd_ff;
   logic [lcdnw_pkg::WAIT_W-1:0]          cmd_wait_ff;
   logic [lcdnw_pkg::WAIT_W-1:0]          data_wait_ff;

   logic                                  req_fire;
   logic                                  rsp_fire;
   logic                                  zero_number;
   logic                                  more_digits;
   logic                                  div_start;
   logic [lcdnw_pkg::VALUE_W-1:0]         div_dividend;
   logic [lcdnw_pkg::VALUE_W-1:0]         div_quotient;
   logic [lcdnw_pkg::REM_W-1:0]           div_remainder;
   lcdnw_pkg::div_status_type             div_status;

   logic [lcdnw_pkg::BYTE_W-1:0]          cur_byte;
   logic                                  cur_last;

   assign req_mode    = lcdnw_pkg::mode_type'(req_ch.mode);
   assign req_fire    = req_ch.valid && req_ch.ready;
   assign rsp_fire    = rsp_ch.valid && rsp_ch.ready;
   assign zero_number = req_ch.value == '0;
   assign count_inc   = count_ff + 1'b1;
   assign count_dec   = count_ff - 1'b1;
   assign more_digits = (div_quotient != '0) && (count_inc < CNT_W'(MAX_DIGITS));

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_cmd_ff    <= lcdnw_pkg::FUNCTION_SET_RESET;
         dc_cmd_ff    <= lcdnw_pkg::DISPLAY_CONTROL_RESET;
         cmd_wait_ff  <= lcdnw_pkg::COMMAND_WAIT_RESET;
         data_wait_ff <= lcdnw_pkg::DATA_WAIT_RESET;
      end else if (csr_we) begin
         unique case (lcdnw_pkg::csr_index_type'(csr_index))
            lcdnw_pkg::CSR_FUNCTION_SET:    fs_cmd_ff    <= csr_wdata[lcdnw_pkg::BYTE_W-1:0];
            lcdnw_pkg::CSR_DISPLAY_CONTROL: dc_cmd_ff    <= csr_wdata[lcdnw_pkg::BYTE_W-1:0];
            lcdnw_pkg::CSR_COMMAND_WAIT:    cmd_wait_ff  <= csr_wdata;
            lcdnw_pkg::CSR_DATA_WAIT:       data_wait_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcdnw_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == lcdnw_pkg::MODE_NUMBER && !zero_number) begin
                  state_in = lcdnw_pkg::ST_DIVIDE;
               end else begin
                  state_in = lcdnw_pkg::ST_SEND;
               end
            end
         end
         lcdnw_pkg::ST_DIVIDE: begin
            if (div_status.done && !more_digits) begin
               state_in = lcdnw_pkg::ST_SEND;
            end
         end
         lcdnw_pkg::ST_SEND: begin
            if (rsp_fire && cur_last) begin
               state_in = lcdnw_pkg::ST_IDLE;
            end
         end
         default: state_in = lcdnw_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      unique case (state_ff)
         lcdnw_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            div_dividend = req_ch.value;
            div_start    = req_ch.valid && req_mode == lcdnw_pkg::MODE_NUMBER && !zero_number;
         end
         lcdnw_pkg::ST_DIVIDE: begin
            div_start = div_status.done && more_digits;
         end
         lcdnw_pkg::ST_SEND: begin
            rsp_ch.valid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcdnw_pkg::ST_IDLE;
         mode_ff  <= lcdnw_pkg::MODE_COMMAND;
         high_ff  <= 1'b1;
         step_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            mode_ff  <= req_mode;
            high_ff  <= 1'b1;
            step_ff  <= '0;
            count_ff <= (req_mode == lcdnw_pkg::MODE_NUMBER && zero_number) ? CNT_W'(1) : '0;
         end else if (state_ff == lcdnw_pkg::ST_DIVIDE && div_status.done) begin
            count_ff <= count_inc;
         end else if (rsp_fire) begin
            high_ff <= !high_ff;
            if (!high_ff) begin
               step_ff <= step_ff + 1'b1;
               if (mode_ff == lcdnw_pkg::MODE_NUMBER) begin
                  count_ff <= count_dec;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_ch.value[lcdnw_pkg::BYTE_W-1:0];
      end
   end

   // digit store, least significant digit first
   always_ff @(posedge clock) begin
      if (req_fire && req_mode == lcdnw_pkg::MODE_NUMBER && zero_number) begin
         digit_store[0] <= '0;
      end else if (state_ff == lcdnw_pkg::ST_DIVIDE && div_status.done) begin
         digit_store[count_ff[IDX_W-1:0]] <= div_remainder;
      end
   end

   lcdnw_div10 u_div10 (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   // strobe payload
   always_comb begin
      case (mode_ff)
         lcdnw_pkg::MODE_NUMBER: begin
            cur_byte = lcdnw_pkg::ASCII_ZERO
                     + lcdnw_pkg::BYTE_W'(digit_store[count_dec[IDX_W-1:0]]);
            cur_last = !high_ff && count_ff == CNT_W'(1);
         end
         lcdnw_pkg::MODE_INIT: begin
            cur_byte = lcdnw_pkg::init_command(step_ff, fs_cmd_ff, dc_cmd_ff);
            cur_last = !high_ff && step_ff == lcdnw_pkg::INIT_LAST_STEP;
         end
         default: begin
            cur_byte = byte_ff;
            cur_last = !high_ff;
         end
      endcase
   end

   always_comb begin
      rsp_ch.reg_select  = mode_ff inside {lcdnw_pkg::MODE_DATA, lcdnw_pkg::MODE_NUMBER};
      rsp_ch.nibble      = high_ff ? cur_byte[7:4] : cur_byte[3:0];
      rsp_ch.strobe_wait = rsp_ch.reg_select ? data_wait_ff : cmd_wait_ff;
      rsp_ch.pause_after = (mode_ff == lcdnw_pkg::MODE_INIT && !high_ff)
                           ? lcdnw_pkg::init_pause(step_ff) : '0;
      rsp_ch.last        = cur_last;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request accepted while strobes pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count beyond store depth");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_ch.last |=> state_ff == lcdnw_pkg::ST_IDLE)
      else $error("sequencer not idle after last strobe");

   a_div_done_place: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == lcdnw_pkg::ST_DIVIDE)
      else $error("divide result outside conversion");

   a_number_has_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff == lcdnw_pkg::ST_SEND && mode_ff == lcdnw_pkg::MODE_NUMBER |-> count_ff != '0)
      else $error("number send with empty digit store");

endmodule

`default_nettype wire
